// ----- rtl/core/mfde_pkg.sv -----
// Shared types, constants and ROM tables for the monochrome framebuffer draw engine.
// Used by mfde_ctrl, mfde_dpath and the top level; depends on nothing else.
package mfde_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int MAX_PAGES    = 8;
  localparam int DEPTH        = MAX_PAGES * PANEL_WIDTH;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int PAGES_W      = $clog2(MAX_PAGES + 1);
  localparam int COORD_W      = 16;
  localparam int GLYPH_COLS   = 8;
  localparam int FIRST_CODE   = 32;
  localparam int LAST_CODE    = 127;
  localparam int FULL_PERCENT = 100;
  localparam int BAR_COLS     = 6;
  localparam logic [7:0] BAR_BYTE = 8'h7E;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;
  localparam logic [1:0] REG_PANEL_HEIGHT = 2'd0;

  localparam logic [3:0] KIND_PIXEL  = 4'd0;
  localparam logic [3:0] KIND_LINE   = 4'd1;
  localparam logic [3:0] KIND_RECT   = 4'd2;
  localparam logic [3:0] KIND_FILL   = 4'd3;
  localparam logic [3:0] KIND_CIRCLE = 4'd4;
  localparam logic [3:0] KIND_GLYPH  = 4'd5;
  localparam logic [3:0] KIND_BATT   = 4'd6;
  localparam logic [3:0] KIND_CLEAR  = 4'd7;
  localparam logic [3:0] KIND_CLPAGE = 4'd8;
  localparam logic [3:0] KIND_READ   = 4'd9;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_INVERT = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    CLS_POINTS,
    CLS_BYTES,
    CLS_READ,
    CLS_NONE
  } cls_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [10:0] start_x;
    logic [10:0] start_y;
    logic [10:0] end_x;
    logic [10:0] end_y;
    logic [10:0] extent_w;
    logic [10:0] extent_h;
    logic [10:0] radius;
    logic [1:0]  color_op;
    logic [7:0]  char_code;
    logic [7:0]  percentage;
    logic [7:0]  page;
  } req_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic pix_rd;
    logic pix_wr;
    logic byte_wr;
    logic init_wr;
    logic byte_rd;
    logic fetch;
    logic emit;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic gen_done;
    logic visible;
    logic cnt_last;
    logic init_last;
  } stat_t;

  function automatic coord_t ext11(input logic [10:0] v);
    return coord_t'($signed(v));
  endfunction

  localparam logic [7:0] BATT_ROM [10] = '{
    8'hFF, 8'h81, 8'hBD, 8'hBD, 8'hBD, 8'h81, 8'hFF, 8'h18, 8'h00, 8'h00
  };

  localparam logic [7:0] FONT_ROM [96][8] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h07,8'h00,8'h07,8'h00,8'h00,8'h00},
    '{8'h00,8'h14,8'h7F,8'h14,8'h7F,8'h14,8'h00,8'h00},
    '{8'h00,8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h00,8'h00},
    '{8'h00,8'h23,8'h13,8'h08,8'h64,8'h62,8'h00,8'h00},
    '{8'h00,8'h36,8'h49,8'h55,8'h22,8'h50,8'h00,8'h00},
    '{8'h00,8'h00,8'h05,8'h03,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h41,8'h22,8'h1C,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h08,8'h2A,8'h1C,8'h2A,8'h08,8'h00,8'h00},
    '{8'h00,8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00,8'h00},
    '{8'h00,8'hA0,8'h60,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,8'h00,8'h00},
    '{8'h00,8'h60,8'h60,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h20,8'h10,8'h08,8'h04,8'h02,8'h00,8'h00},
    '{8'h00,8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00,8'h00},
    '{8'h00,8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00,8'h00},
    '{8'h00,8'h62,8'h51,8'h49,8'h49,8'h46,8'h00,8'h00},
    '{8'h00,8'h22,8'h41,8'h49,8'h49,8'h36,8'h00,8'h00},
    '{8'h00,8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00,8'h00},
    '{8'h00,8'h27,8'h45,8'h45,8'h45,8'h39,8'h00,8'h00},
    '{8'h00,8'h3C,8'h4A,8'h49,8'h49,8'h30,8'h00,8'h00},
    '{8'h00,8'h01,8'h71,8'h09,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h36,8'h49,8'h49,8'h49,8'h36,8'h00,8'h00},
    '{8'h00,8'h06,8'h49,8'h49,8'h29,8'h1E,8'h00,8'h00},
    '{8'h00,8'h00,8'h36,8'h36,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'hAC,8'h6C,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00,8'h00,8'h00},
    '{8'h00,8'h14,8'h14,8'h14,8'h14,8'h14,8'h00,8'h00},
    '{8'h00,8'h41,8'h22,8'h14,8'h08,8'h00,8'h00,8'h00},
    '{8'h00,8'h02,8'h01,8'h51,8'h09,8'h06,8'h00,8'h00},
    '{8'h00,8'h32,8'h49,8'h79,8'h41,8'h3E,8'h00,8'h00},
    '{8'h00,8'h7E,8'h09,8'h09,8'h09,8'h7E,8'h00,8'h00},
    '{8'h00,8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00,8'h00},
    '{8'h00,8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00,8'h00},
    '{8'h00,8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h00,8'h00},
    '{8'h00,8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00,8'h00},
    '{8'h00,8'h7F,8'h09,8'h09,8'h09,8'h01,8'h00,8'h00},
    '{8'h00,8'h3E,8'h41,8'h41,8'h51,8'h72,8'h00,8'h00},
    '{8'h00,8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00,8'h00},
    '{8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h20,8'h40,8'h41,8'h3F,8'h01,8'h00,8'h00},
    '{8'h00,8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00,8'h00},
    '{8'h00,8'h7F,8'h40,8'h40,8'h40,8'h40,8'h00,8'h00},
    '{8'h00,8'h7F,8'h02,8'h0C,8'h02,8'h7F,8'h00,8'h00},
    '{8'h00,8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h00,8'h00},
    '{8'h00,8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00,8'h00},
    '{8'h00,8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00,8'h00},
    '{8'h00,8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00,8'h00},
    '{8'h00,8'h7F,8'h09,8'h19,8'h29,8'h46,8'h00,8'h00},
    '{8'h00,8'h26,8'h49,8'h49,8'h49,8'h32,8'h00,8'h00},
    '{8'h00,8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00,8'h00},
    '{8'h00,8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00,8'h00},
    '{8'h00,8'h1F,8'h20,8'h40,8'h20,8'h1F,8'h00,8'h00},
    '{8'h00,8'h3F,8'h40,8'h38,8'h40,8'h3F,8'h00,8'h00},
    '{8'h00,8'h63,8'h14,8'h08,8'h14,8'h63,8'h00,8'h00},
    '{8'h00,8'h03,8'h04,8'h78,8'h04,8'h03,8'h00,8'h00},
    '{8'h00,8'h61,8'h51,8'h49,8'h45,8'h43,8'h00,8'h00},
    '{8'h00,8'h7F,8'h41,8'h41,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h02,8'h04,8'h08,8'h10,8'h20,8'h00,8'h00},
    '{8'h00,8'h41,8'h41,8'h7F,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h04,8'h02,8'h01,8'h02,8'h04,8'h00,8'h00},
    '{8'h00,8'h80,8'h80,8'h80,8'h80,8'h80,8'h00,8'h00},
    '{8'h00,8'h01,8'h02,8'h04,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h20,8'h54,8'h54,8'h54,8'h78,8'h00,8'h00},
    '{8'h00,8'h7F,8'h48,8'h44,8'h44,8'h38,8'h00,8'h00},
    '{8'h00,8'h38,8'h44,8'h44,8'h28,8'h00,8'h00,8'h00},
    '{8'h00,8'h38,8'h44,8'h44,8'h48,8'h7F,8'h00,8'h00},
    '{8'h00,8'h38,8'h54,8'h54,8'h54,8'h18,8'h00,8'h00},
    '{8'h00,8'h08,8'h7E,8'h09,8'h02,8'h00,8'h00,8'h00},
    '{8'h00,8'h18,8'hA4,8'hA4,8'hA4,8'h7C,8'h00,8'h00},
    '{8'h00,8'h7F,8'h08,8'h04,8'h04,8'h78,8'h00,8'h00},
    '{8'h00,8'h00,8'h7D,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h80,8'h84,8'h7D,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00,8'h00,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h7C,8'h04,8'h18,8'h04,8'h78,8'h00,8'h00},
    '{8'h00,8'h7C,8'h08,8'h04,8'h7C,8'h00,8'h00,8'h00},
    '{8'h00,8'h38,8'h44,8'h44,8'h38,8'h00,8'h00,8'h00},
    '{8'h00,8'hFC,8'h24,8'h24,8'h18,8'h00,8'h00,8'h00},
    '{8'h00,8'h18,8'h24,8'h24,8'hFC,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h7C,8'h08,8'h04,8'h00,8'h00,8'h00},
    '{8'h00,8'h48,8'h54,8'h54,8'h24,8'h00,8'h00,8'h00},
    '{8'h00,8'h04,8'h7F,8'h44,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h3C,8'h40,8'h40,8'h7C,8'h00,8'h00,8'h00},
    '{8'h00,8'h1C,8'h20,8'h40,8'h20,8'h1C,8'h00,8'h00},
    '{8'h00,8'h3C,8'h40,8'h30,8'h40,8'h3C,8'h00,8'h00},
    '{8'h00,8'h44,8'h28,8'h10,8'h28,8'h44,8'h00,8'h00},
    '{8'h00,8'h1C,8'hA0,8'hA0,8'h7C,8'h00,8'h00,8'h00},
    '{8'h00,8'h44,8'h64,8'h54,8'h4C,8'h44,8'h00,8'h00},
    '{8'h00,8'h08,8'h36,8'h41,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h41,8'h36,8'h08,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h02,8'h01,8'h01,8'h02,8'h01,8'h00,8'h00},
    '{8'h00,8'h02,8'h05,8'h05,8'h02,8'h00,8'h00,8'h00}
  };

endpackage

// ----- rtl/core/mfde_ctrl.sv -----
// Sequencing state machine of the draw engine: accepts requests, steps the datapath.
// Depends on mfde_pkg for the command and status structs.
module mfde_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mfde_pkg::stat_t st,
  output mfde_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_POINT,
    ST_MODIFY,
    ST_BYTES,
    ST_READ,
    ST_FETCH,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit_ok;

  assign emit_ok  = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        case (st.cls)
          mfde_pkg::CLS_POINTS: state_next = ST_POINT;
          mfde_pkg::CLS_BYTES:  state_next = ST_BYTES;
          mfde_pkg::CLS_READ:   state_next = ST_READ;
          default:              state_next = ST_DONE;
        endcase
      end
      ST_POINT: begin
        if (st.gen_done) begin
          state_next = ST_DONE;
        end else if (st.visible) begin
          cmd.pix_rd = 1'b1;
          state_next = ST_MODIFY;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_MODIFY: begin
        cmd.pix_wr = 1'b1;
        cmd.advance = 1'b1;
        state_next = ST_POINT;
      end
      ST_BYTES: begin
        cmd.byte_wr = 1'b1;
        if (st.cnt_last) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.byte_rd = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (emit_ok) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/mfde_dpath.sv -----
// Datapath of the draw engine: point generators, framebuffer memory and result registers.
// Depends on mfde_pkg; driven by commands from mfde_ctrl.
module mfde_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  mfde_pkg::req_t                req,
  input  logic [mfde_pkg::PAGES_W-1:0]  pages,
  input  mfde_pkg::cmd_t                cmd,
  output mfde_pkg::stat_t               st,
  output logic [7:0]                    read_data,
  output logic                          rejected
);

  localparam int AW = mfde_pkg::ADDR_W;

  logic [7:0]      mem [mfde_pkg::DEPTH];
  logic [7:0]      rdata;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;

  logic [3:0]            kind;
  logic [1:0]            op;
  mfde_pkg::cls_t        cls;
  logic                  gen_done;
  mfde_pkg::coord_t      org_x, org_y, cur_x, cur_y, lim_x, lim_y, lo_x;
  mfde_pkg::coord_t      dxa, dya, err;
  logic                  step_x, step_y;
  logic [2:0]            oct;
  logic [AW-1:0]         cnt, base_addr, byte_last;
  logic [6:0]            gidx;
  logic [9:0]            pct6;
  logic [AW-1:0]         pix_addr;
  logic [7:0]            pix_bit;
  logic [7:0]            res_data;
  logic                  res_rej;

  mfde_pkg::coord_t      rows;
  mfde_pkg::coord_t      in_sx, in_sy, in_ex, in_ey, in_w, in_h, in_r;
  mfde_pkg::coord_t      f_xlo, f_xhi, f_ylo, f_yhi, l_dx, l_dy;
  logic                  page_ok, cell_ok, col_ok, rej_in;
  logic [AW-1:0]         cell_addr, page_addr;
  logic [6:0]            pct_c;

  mfde_pkg::coord_t      px, py;
  logic                  visible;
  logic [AW-1:0]         pt_addr;

  mfde_pkg::coord_t      e2, l_err_n, l_x_n, l_y_n;
  mfde_pkg::coord_t      c_y_n, c_x_n, c_d_n;
  mfde_pkg::coord_t      r_len;
  logic [7:0]            byte_val, batt_val;
  logic [7:0]            mod_val;

  assign rows = mfde_pkg::coord_t'({pages, 3'b000});

  always_comb begin
    in_sx = mfde_pkg::ext11(req.start_x);
    in_sy = mfde_pkg::ext11(req.start_y);
    in_ex = mfde_pkg::ext11(req.end_x);
    in_ey = mfde_pkg::ext11(req.end_y);
    in_w  = mfde_pkg::ext11(req.extent_w);
    in_h  = mfde_pkg::ext11(req.extent_h);
    in_r  = mfde_pkg::ext11(req.radius);
    f_xlo = (in_sx < 0) ? '0 : in_sx;
    f_ylo = (in_sy < 0) ? '0 : in_sy;
    f_xhi = in_sx + in_w;
    f_yhi = in_sy + in_h;
    if (f_xhi > mfde_pkg::coord_t'(mfde_pkg::PANEL_WIDTH)) begin
      f_xhi = mfde_pkg::coord_t'(mfde_pkg::PANEL_WIDTH);
    end
    if (f_yhi > rows) begin
      f_yhi = rows;
    end
    l_dx = in_ex - in_sx;
    l_dy = in_ey - in_sy;
    page_ok = {{(8-mfde_pkg::PAGES_W){1'b0}}, pages} > req.page;
    cell_ok = page_ok && (in_sx >= 0) &&
              (in_sx + mfde_pkg::coord_t'(mfde_pkg::GLYPH_COLS) <=
               mfde_pkg::coord_t'(mfde_pkg::PANEL_WIDTH));
    col_ok  = page_ok && (in_sx >= 0) &&
              (in_sx < mfde_pkg::coord_t'(mfde_pkg::PANEL_WIDTH));
    page_addr = AW'(32'(req.page) * mfde_pkg::PANEL_WIDTH);
    cell_addr = page_addr + AW'(in_sx);
    pct_c = (req.percentage > 8'(mfde_pkg::FULL_PERCENT)) ?
            7'(mfde_pkg::FULL_PERCENT) : req.percentage[6:0];
    case (req.kind)
      mfde_pkg::KIND_GLYPH, mfde_pkg::KIND_BATT: rej_in = !cell_ok;
      mfde_pkg::KIND_CLPAGE:                     rej_in = !page_ok;
      mfde_pkg::KIND_READ:                       rej_in = !col_ok;
      default:                                   rej_in = 1'b0;
    endcase
  end

  always_comb begin
    px = org_x;
    py = org_y;
    case (kind)
      mfde_pkg::KIND_LINE, mfde_pkg::KIND_FILL: begin
        px = cur_x;
        py = cur_y;
      end
      mfde_pkg::KIND_RECT: begin
        case (oct[1:0])
          2'd0: begin px = org_x + cur_x; py = org_y; end
          2'd1: begin px = org_x + cur_x; py = org_y + lim_y - 2'sd1; end
          2'd2: begin px = org_x; py = org_y + cur_x; end
          default: begin px = org_x + lim_x - 2'sd1; py = org_y + cur_x; end
        endcase
      end
      mfde_pkg::KIND_CIRCLE: begin
        case (oct)
          3'd0: begin px = org_x + cur_x; py = org_y + cur_y; end
          3'd1: begin px = org_x - cur_x; py = org_y + cur_y; end
          3'd2: begin px = org_x + cur_x; py = org_y - cur_y; end
          3'd3: begin px = org_x - cur_x; py = org_y - cur_y; end
          3'd4: begin px = org_x + cur_y; py = org_y + cur_x; end
          3'd5: begin px = org_x - cur_y; py = org_y + cur_x; end
          3'd6: begin px = org_x + cur_y; py = org_y - cur_x; end
          default: begin px = org_x - cur_y; py = org_y - cur_x; end
        endcase
      end
      default: begin
        px = org_x;
        py = org_y;
      end
    endcase
    visible = (px >= 0) && (px < mfde_pkg::coord_t'(mfde_pkg::PANEL_WIDTH)) &&
              (py >= 0) && (py < rows);
    pt_addr = AW'(32'(py[mfde_pkg::COORD_W-1:3]) * mfde_pkg::PANEL_WIDTH + 32'(px));
  end

  always_comb begin
    e2 = err <<< 1;
    l_err_n = err;
    l_x_n = cur_x;
    l_y_n = cur_y;
    if (e2 > -dya) begin
      l_err_n = l_err_n - dya;
      l_x_n = step_x ? cur_x + 2'sd1 : cur_x - 2'sd1;
    end
    if (e2 < dxa) begin
      l_err_n = l_err_n + dxa;
      l_y_n = step_y ? cur_y + 2'sd1 : cur_y - 2'sd1;
    end
    c_y_n = cur_y + 2'sd1;
    if (err <= 0) begin
      c_x_n = cur_x;
      c_d_n = err + (c_y_n <<< 1) + 2'sd1;
    end else begin
      c_x_n = cur_x - 2'sd1;
      c_d_n = err + ((c_y_n - c_x_n) <<< 1) + 2'sd1;
    end
    r_len = oct[1] ? lim_y : lim_x;
  end

  always_comb begin
    batt_val = mfde_pkg::BATT_ROM[cnt[2:0]];
    if ((cnt[2:0] != 3'd0) && (cnt[2:0] <= 3'(mfde_pkg::BAR_COLS)) &&
        ({1'b0, pct6} >= 11'(mfde_pkg::FULL_PERCENT) * 11'(cnt[2:0]))) begin
      batt_val = batt_val | mfde_pkg::BAR_BYTE;
    end
    case (kind)
      mfde_pkg::KIND_GLYPH: byte_val = mfde_pkg::FONT_ROM[gidx][cnt[2:0]];
      mfde_pkg::KIND_BATT:  byte_val = batt_val;
      default:              byte_val = 8'h00;
    endcase
    case (op)
      mfde_pkg::OP_SET:    mod_val = rdata | pix_bit;
      mfde_pkg::OP_CLEAR:  mod_val = rdata & ~pix_bit;
      mfde_pkg::OP_INVERT: mod_val = rdata ^ pix_bit;
      default:             mod_val = rdata;
    endcase
  end

  always_comb begin
    raddr = cmd.byte_rd ? base_addr : pt_addr;
    we = cmd.pix_wr || cmd.byte_wr || cmd.init_wr;
    if (cmd.pix_wr) begin
      waddr = pix_addr;
      wdata = mod_val;
    end else if (cmd.byte_wr) begin
      waddr = base_addr + cnt;
      wdata = byte_val;
    end else begin
      waddr = cnt;
      wdata = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.init_wr) begin
      cnt <= (cnt == AW'(mfde_pkg::DEPTH - 1)) ? '0 : cnt + 1'b1;
    end else if (cmd.byte_wr) begin
      cnt <= (cnt == byte_last) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req.kind;
      op <= req.color_op;
      org_x <= in_sx;
      org_y <= in_sy;
      oct <= '0;
      res_rej <= rej_in;
      res_data <= 8'h00;
      gidx <= ((req.char_code < 8'(mfde_pkg::FIRST_CODE)) ||
               (req.char_code > 8'(mfde_pkg::LAST_CODE))) ?
              7'd0 : 7'(req.char_code - 8'(mfde_pkg::FIRST_CODE));
      pct6 <= 10'(pct_c) * 10'd6;
      base_addr <= cell_addr;
      byte_last <= AW'(mfde_pkg::GLYPH_COLS - 1);
      gen_done <= 1'b0;
      cur_x <= in_sx;
      cur_y <= in_sy;
      lim_x <= in_ex;
      lim_y <= in_ey;
      lo_x <= f_xlo;
      step_x <= (l_dx > 0);
      step_y <= (l_dy > 0);
      dxa <= (l_dx < 0) ? -l_dx : l_dx;
      dya <= (l_dy < 0) ? -l_dy : l_dy;
      err <= ((l_dx < 0) ? -l_dx : l_dx) - ((l_dy < 0) ? -l_dy : l_dy);
      case (req.kind)
        mfde_pkg::KIND_PIXEL, mfde_pkg::KIND_LINE, mfde_pkg::KIND_RECT,
        mfde_pkg::KIND_FILL, mfde_pkg::KIND_CIRCLE: cls <= mfde_pkg::CLS_POINTS;
        mfde_pkg::KIND_GLYPH, mfde_pkg::KIND_BATT, mfde_pkg::KIND_CLPAGE:
          cls <= rej_in ? mfde_pkg::CLS_NONE : mfde_pkg::CLS_BYTES;
        mfde_pkg::KIND_CLEAR: cls <= mfde_pkg::CLS_BYTES;
        mfde_pkg::KIND_READ: cls <= rej_in ? mfde_pkg::CLS_NONE : mfde_pkg::CLS_READ;
        default: cls <= mfde_pkg::CLS_NONE;
      endcase
      case (req.kind)
        mfde_pkg::KIND_RECT: begin
          cur_x <= '0;
          lim_x <= in_w;
          lim_y <= in_h;
          gen_done <= (in_w <= 0) || (in_h <= 0);
        end
        mfde_pkg::KIND_FILL: begin
          cur_x <= f_xlo;
          cur_y <= f_ylo;
          lim_x <= f_xhi;
          lim_y <= f_yhi;
          gen_done <= (in_w <= 0) || (in_h <= 0) || (f_xlo >= f_xhi) || (f_ylo >= f_yhi);
        end
        mfde_pkg::KIND_CIRCLE: begin
          cur_x <= in_r;
          cur_y <= '0;
          err <= 2'sd1 - in_r;
          gen_done <= (in_r < 0);
        end
        mfde_pkg::KIND_CLEAR: begin
          base_addr <= '0;
          byte_last <= AW'(mfde_pkg::DEPTH - 1);
        end
        mfde_pkg::KIND_CLPAGE: begin
          base_addr <= page_addr;
          byte_last <= AW'(mfde_pkg::PANEL_WIDTH - 1);
        end
        default: ;
      endcase
    end else if (cmd.advance) begin
      case (kind)
        mfde_pkg::KIND_LINE: begin
          if ((cur_x == lim_x) && (cur_y == lim_y)) begin
            gen_done <= 1'b1;
          end else begin
            cur_x <= l_x_n;
            cur_y <= l_y_n;
            err <= l_err_n;
          end
        end
        mfde_pkg::KIND_RECT: begin
          if (cur_x == r_len - 2'sd1) begin
            if (oct[1:0] == 2'd3) begin
              gen_done <= 1'b1;
            end else begin
              oct <= oct + 3'd1;
              cur_x <= '0;
            end
          end else begin
            cur_x <= cur_x + 2'sd1;
          end
        end
        mfde_pkg::KIND_FILL: begin
          if (cur_x == lim_x - 2'sd1) begin
            if (cur_y == lim_y - 2'sd1) begin
              gen_done <= 1'b1;
            end else begin
              cur_y <= cur_y + 2'sd1;
              cur_x <= lo_x;
            end
          end else begin
            cur_x <= cur_x + 2'sd1;
          end
        end
        mfde_pkg::KIND_CIRCLE: begin
          if (oct != 3'd7) begin
            oct <= oct + 3'd1;
          end else begin
            oct <= '0;
            cur_x <= c_x_n;
            cur_y <= c_y_n;
            err <= c_d_n;
            gen_done <= (c_x_n < c_y_n);
          end
        end
        default: gen_done <= 1'b1;
      endcase
    end
    if (cmd.pix_rd) begin
      pix_addr <= pt_addr;
      pix_bit <= 8'(1) << py[2:0];
    end
    if (cmd.fetch) begin
      res_data <= rdata;
    end
    if (cmd.emit) begin
      read_data <= res_data;
      rejected <= res_rej;
    end
  end

  always_comb begin
    st.cls = cls;
    st.gen_done = gen_done;
    st.visible = visible;
    st.cnt_last = (cnt == byte_last);
    st.init_last = (cnt == AW'(mfde_pkg::DEPTH - 1));
  end

endmodule

// ----- rtl/core/monochrome_framebuffer_draw_engine_top.sv -----
// Top level of the monochrome framebuffer draw engine.
// Command and result streams, APB register port; uses mfde_pkg, mfde_ctrl, mfde_dpath.
// After reset the framebuffer is zeroed by a pass over all 1024 bytes; no request is taken then.
// A drawing command steps through its points and reads, modifies and writes each visible
// pixel; glyph and battery write their eight columns, clear page and clear all write zero
// bytes, read fetches one byte. The next request can be taken as the result is presented.
module monochrome_framebuffer_draw_engine_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33], extent_w[54:44],
  // extent_h[65:55], radius[76:66], color_op[78:77], char_code[86:79],
  // percentage[94:87], page[102:95], zero pad[103]
  input  logic [103:0] s_tdata,
  // kind[3:0]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_data[7:0]
  output logic [7:0]   m_tdata,
  // rejected[0]
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [6:0]                      panel_height;
  logic [mfde_pkg::PAGES_W-1:0]    pages;
  mfde_pkg::req_t                  req;
  mfde_pkg::cmd_t                  cmd;
  mfde_pkg::stat_t                 st;

  assign pready = 1'b1;
  assign prdata = (paddr == mfde_pkg::REG_PANEL_HEIGHT) ? {25'd0, panel_height} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_height <= mfde_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == mfde_pkg::REG_PANEL_HEIGHT)) begin
      panel_height <= pwdata[6:0];
    end
  end

  always_comb begin
    if (panel_height[6:3] > 4'(mfde_pkg::MAX_PAGES)) begin
      pages = mfde_pkg::PAGES_W'(mfde_pkg::MAX_PAGES);
    end else begin
      pages = mfde_pkg::PAGES_W'(panel_height[6:3]);
    end
    req.kind       = s_tuser;
    req.start_x    = s_tdata[10:0];
    req.start_y    = s_tdata[21:11];
    req.end_x      = s_tdata[32:22];
    req.end_y      = s_tdata[43:33];
    req.extent_w   = s_tdata[54:44];
    req.extent_h   = s_tdata[65:55];
    req.radius     = s_tdata[76:66];
    req.color_op   = s_tdata[78:77];
    req.char_code  = s_tdata[86:79];
    req.percentage = s_tdata[94:87];
    req.page       = s_tdata[102:95];
  end

  mfde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  mfde_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .pages     (pages),
    .cmd       (cmd),
    .st        (st),
    .read_data (m_tdata),
    .rejected  (m_tuser)
  );

endmodule
